### hw/rtl/xcfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_pkg
// Types and constants for the checked frame parser: error codes, header fault
// codes, frame constants and the result word layout.
// ----------------------------------------------------------------------------
package xcfp_pkg;

   localparam logic [7:0]  PREAMBLE_BYTE  = 8'hFE;
   localparam logic [16:0] FRAME_OVERHEAD = 17'd5;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam logic [15:0] MIN_FRAME_LEN  = 16'd6;

   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      ERR_OK           = 3'd0,
      ERR_ONLY_PREAMBLE = 3'd1,
      ERR_BAD_START    = 3'd2,
      ERR_CMD_MISMATCH = 3'd3,
      ERR_BAD_END      = 3'd4,
      ERR_LENGTH       = 3'd5,
      ERR_CHECKSUM     = 3'd6
   } err_code_type;

   typedef enum logic [1:0] {
      HDR_NONE      = 2'd0,
      HDR_BAD_START = 2'd1,
      HDR_BAD_CMD   = 2'd2
   } hdr_err_type;

   typedef enum logic [1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_END_MARKER   = 2'd1,
      CSR_EXP_COMMAND  = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_VERDICT = 1'b1
   } rsp_kind_type;

   typedef struct packed {
      logic [4:0]   pad;
      err_code_type error_code;
      logic [7:0]   status_byte;
      logic [7:0]   data_byte;
   } rsp_word_type;

endpackage

### hw/rtl/xor_checked_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// Streaming deframer for start/length/command/status/data/end/BCC replies.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while req_tready is high. Leading 0xFE
// preamble bytes are dropped; payload bytes from offset 6 come out as data
// words (kind 0) and the byte flagged tlast yields one verdict word (kind 1)
// with the status byte and an error code. Each accepted byte is evaluated in
// the cycle it is taken and its result lands in a single output register in
// the next cycle. req_tready stays high while the output register is empty or
// being drained. Discard payload of a frame whose verdict is not ok.
// Configuration writes are meant for an idle block.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // rx_byte
   input  logic                            req_tlast,   // last_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [xcfp_pkg::RSP_DATA_W-1:0] rsp_tdata,   // data_byte, status_byte,
                                                        // error_code, zero pad
   output logic                            rsp_tuser,   // kind
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [15:0]                     csr_wdata
);
   import xcfp_pkg::*;

   logic [7:0]   start_marker_ff;
   logic [7:0]   end_marker_ff;
   logic [15:0]  exp_command_ff;

   logic         in_preamble_ff, in_preamble_in;
   logic [15:0]  byte_count_ff, byte_count_in;
   logic [15:0]  length_field_ff, length_field_in;
   logic [7:0]   running_xor_ff, running_xor_in;
   logic [7:0]   prev_byte_ff, prev_byte_in;
   hdr_err_type  hdr_err_ff, hdr_err_in;
   logic [7:0]   held_status_ff, held_status_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   rsp_kind_type rsp_kind_ff, rsp_kind_in;

   logic         accept;
   logic         emit;
   logic         skip_pre;
   logic [15:0]  total_len;
   logic [16:0]  len_plus;
   logic [16:0]  payload_end;
   err_code_type verdict;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign skip_pre   = in_preamble_ff && (req_tdata == PREAMBLE_BYTE);

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= 8'd2;
         end_marker_ff   <= 8'd3;
         exp_command_ff  <= 16'd0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_START_MARKER: start_marker_ff <= csr_wdata[7:0];
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata[7:0];
            CSR_EXP_COMMAND:  exp_command_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_preamble_in  = in_preamble_ff;
      byte_count_in   = byte_count_ff;
      length_field_in = length_field_ff;
      running_xor_in  = running_xor_ff;
      prev_byte_in    = prev_byte_ff;
      hdr_err_in      = hdr_err_ff;
      held_status_in  = held_status_ff;
      emit            = 1'b0;
      rsp_word_in     = '0;
      rsp_kind_in     = KIND_DATA;
      verdict         = ERR_OK;
      total_len       = (byte_count_ff < COUNT_MAX) ? byte_count_ff + 16'd1 : COUNT_MAX;

      // header capture for this byte, visible to a same-cycle verdict
      case (byte_count_ff)
         16'd0: if (req_tdata != start_marker_ff && hdr_err_ff == HDR_NONE)
                   hdr_err_in = HDR_BAD_START;
         16'd1: length_field_in = {req_tdata, 8'd0};
         16'd2: length_field_in = {length_field_ff[15:8], req_tdata};
         16'd3: if (req_tdata != exp_command_ff[15:8] && hdr_err_ff == HDR_NONE)
                   hdr_err_in = HDR_BAD_CMD;
         16'd4: if (req_tdata != exp_command_ff[7:0] && hdr_err_ff == HDR_NONE)
                   hdr_err_in = HDR_BAD_CMD;
         16'd5: held_status_in = req_tdata;
         default: ;
      endcase

      len_plus    = {1'b0, length_field_in} + FRAME_OVERHEAD;
      payload_end = {1'b0, length_field_in} + 17'd2;

      if (total_len < MIN_FRAME_LEN)                  verdict = ERR_LENGTH;
      else if (hdr_err_in == HDR_BAD_START)           verdict = ERR_BAD_START;
      else if (hdr_err_in == HDR_BAD_CMD)             verdict = ERR_CMD_MISMATCH;
      else if (prev_byte_ff != end_marker_ff)         verdict = ERR_BAD_END;
      else if (len_plus != {1'b0, total_len})         verdict = ERR_LENGTH;
      else if (req_tdata != running_xor_ff)           verdict = ERR_CHECKSUM;

      if (skip_pre) begin
         // restore header state untouched while skipping preamble
         length_field_in = length_field_ff;
         hdr_err_in      = hdr_err_ff;
         held_status_in  = held_status_ff;
         if (req_tlast) begin
            emit                   = 1'b1;
            rsp_kind_in            = KIND_VERDICT;
            rsp_word_in.error_code = ERR_ONLY_PREAMBLE;
         end
      end else if (req_tlast) begin
         emit                    = 1'b1;
         rsp_kind_in             = KIND_VERDICT;
         rsp_word_in.status_byte = held_status_in;
         rsp_word_in.error_code  = verdict;
      end else begin
         in_preamble_in = 1'b0;
         running_xor_in = running_xor_ff ^ req_tdata;
         prev_byte_in   = req_tdata;
         if (byte_count_ff < COUNT_MAX)
            byte_count_in = byte_count_ff + 16'd1;
         if (byte_count_ff >= 16'd6 && {1'b0, byte_count_ff} <= payload_end) begin
            emit                  = 1'b1;
            rsp_word_in.data_byte = req_tdata;
         end
      end

      if (req_tlast) begin
         in_preamble_in  = 1'b1;
         byte_count_in   = '0;
         length_field_in = '0;
         running_xor_in  = '0;
         prev_byte_in    = '0;
         hdr_err_in      = HDR_NONE;
         held_status_in  = '0;
      end

      if (accept)
         rsp_valid_in = emit;
      else
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_preamble_ff  <= 1'b1;
         byte_count_ff   <= '0;
         length_field_ff <= '0;
         running_xor_ff  <= '0;
         prev_byte_ff    <= '0;
         hdr_err_ff      <= HDR_NONE;
         held_status_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_preamble_ff  <= in_preamble_in;
            byte_count_ff   <= byte_count_in;
            length_field_ff <= length_field_in;
            running_xor_ff  <= running_xor_in;
            prev_byte_ff    <= prev_byte_in;
            hdr_err_ff      <= hdr_err_in;
            held_status_ff  <= held_status_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_word_ff <= rsp_word_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // checks
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_DATA) |->
         (rsp_word_ff.error_code == ERR_OK && rsp_word_ff.status_byte == 8'd0))
      else $error("data word carries verdict fields");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (in_preamble_ff && byte_count_ff == 16'd0 &&
                                 hdr_err_ff == HDR_NONE && running_xor_ff == 8'd0))
      else $error("frame state not cleared after last byte");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.error_code <= ERR_CHECKSUM))
      else $error("error code out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast && !skip_pre && byte_count_ff != COUNT_MAX) |=>
         (byte_count_ff == $past(byte_count_ff) + 16'd1))
      else $error("byte counter did not advance");

   a_preamble_only: assert property (@(posedge clock) disable iff (reset)
      (accept && skip_pre && !req_tlast) |=> !rsp_valid_ff || $stable(rsp_word_ff))
      else $error("preamble byte produced a result");

endmodule
